>>> src/tpmd_pkg.sv
`timescale 1ns / 1ps

package tpmd_pkg;

  // Width of the scaled motion outputs and their saturation limits.
  localparam int unsigned MotionW = 17;
  localparam logic [MotionW-1:0] MotionPosMax = 17'h0FFFF;  // 65535
  localparam logic [MotionW-1:0] MotionNegMag = 17'h10000;  // magnitude of -65536

  // Configuration field widths.
  localparam int unsigned GainW    = 12;
  localparam int unsigned DeadW    = 8;
  localparam int unsigned MsW      = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 4;

  // Fraction bits of the Q4.8 gain; rounding adds half of one output LSB.
  localparam int unsigned GainFracW = 8;

  // Register reset values.
  localparam logic [GainW-1:0] GainReset   = 12'd256;
  localparam logic [DeadW-1:0] DeadReset   = 8'd1;
  localparam logic [MsW-1:0]   TapMaxReset = 16'd180;
  localparam logic [MsW-1:0]   DblGapReset = 16'd300;

  // Register map, word index (byte address / 4).
  typedef enum logic [1:0] {
    REG_MOTION_GAIN   = 2'd0,
    REG_DEAD_ZONE     = 2'd1,
    REG_TAP_MAX_MS    = 2'd2,
    REG_DOUBLE_GAP_MS = 2'd3
  } tpmd_reg_e;

  // Configuration bundle passed from the register block to the datapath.
  typedef struct packed {
    logic [GainW-1:0] motion_gain;
    logic [DeadW-1:0] dead_zone;
    logic [MsW-1:0]   tap_max_ms;
    logic [MsW-1:0]   double_gap_ms;
  } tpmd_cfg_t;

endpackage

>>> src/tpmd_if.sv
`timescale 1ns / 1ps

// Sensor tick channel.
interface tpmd_in_if #(
  parameter int unsigned COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic                  touch_valid;
  logic [COORD_BITS-1:0] touch_x;
  logic [COORD_BITS-1:0] touch_y;
  logic [31:0]           now_time;

  modport source (output valid, touch_valid, touch_x, touch_y, now_time, input ready);
  modport sink   (input valid, touch_valid, touch_x, touch_y, now_time, output ready);
endinterface

// Motion and click report channel.
interface tpmd_out_if;
  logic        valid;
  logic        ready;
  logic        move_valid;
  logic [16:0] move_dx;
  logic [16:0] move_dy;
  logic        left_click;

  modport source (output valid, move_valid, move_dx, move_dy, left_click, input ready);
  modport sink   (input valid, move_valid, move_dx, move_dy, left_click, output ready);
endinterface

>>> src/tpmd_cfg.sv
`timescale 1ns / 1ps

module tpmd_cfg import tpmd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output tpmd_cfg_t           cfg_o
);

  tpmd_cfg_t cfg_q, cfg_d;
  tpmd_reg_e reg_sel;
  logic      wr_en;

  assign reg_sel = tpmd_reg_e'(paddr[3:2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_MOTION_GAIN:   cfg_d.motion_gain   = pwdata[GainW-1:0];
        REG_DEAD_ZONE:     cfg_d.dead_zone     = pwdata[DeadW-1:0];
        REG_TAP_MAX_MS:    cfg_d.tap_max_ms    = pwdata[MsW-1:0];
        REG_DOUBLE_GAP_MS: cfg_d.double_gap_ms = pwdata[MsW-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.motion_gain   <= GainReset;
      cfg_q.dead_zone     <= DeadReset;
      cfg_q.tap_max_ms    <= TapMaxReset;
      cfg_q.double_gap_ms <= DblGapReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back mux.
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_MOTION_GAIN:   prdata = ApbDataW'(cfg_q.motion_gain);
      REG_DEAD_ZONE:     prdata = ApbDataW'(cfg_q.dead_zone);
      REG_TAP_MAX_MS:    prdata = ApbDataW'(cfg_q.tap_max_ms);
      REG_DOUBLE_GAP_MS: prdata = ApbDataW'(cfg_q.double_gap_ms);
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/tpmd_scale.sv
`timescale 1ns / 1ps

// Scales one signed coordinate delta by the Q4.8 gain, rounding half away
// from zero, and gives both the unsaturated magnitude and the saturated
// 17-bit signed result.
module tpmd_scale import tpmd_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic signed [COORD_BITS:0]   raw_i,
  input  logic        [GainW-1:0]      gain_i,
  output logic        [COORD_BITS+4:0] mag_o,
  output logic        [MotionW-1:0]    value_o
);

  localparam int unsigned ProdW = COORD_BITS + GainW + 1;
  localparam int unsigned QW    = COORD_BITS + 5;
  localparam int unsigned CmpW  = (QW > MotionW + 1) ? QW : MotionW + 1;

  logic                  neg;
  logic [COORD_BITS:0]   raw_abs;
  logic [ProdW-1:0]      prod;
  logic [CmpW-1:0]       q_ext;
  logic [CmpW-1:0]       lim;
  logic [CmpW-1:0]       q_sat;

  assign neg     = raw_i[COORD_BITS];
  assign raw_abs = neg ? ((COORD_BITS+1)'(0) - raw_i) : raw_i;

  // Magnitude times gain plus one half, then drop the fraction.
  assign prod  = ProdW'(raw_abs[COORD_BITS-1:0]) * ProdW'(gain_i)
               + ProdW'(1 << (GainFracW - 1));
  assign mag_o = prod[ProdW-1:GainFracW];

  // Clamp to the 17-bit signed range; the negative side reaches one further.
  assign q_ext   = CmpW'(mag_o);
  assign lim     = neg ? CmpW'(MotionNegMag) : CmpW'(MotionPosMax);
  assign q_sat   = (q_ext > lim) ? lim : q_ext;
  assign value_o = neg ? (MotionW'(0) - q_sat[MotionW-1:0]) : q_sat[MotionW-1:0];

endmodule

>>> src/touchpad_motion_and_double_tap.sv
`timescale 1ns / 1ps

// Channel   Direction  Contents
// in_i      sink       touch_valid, touch_x, touch_y, now_time
// out_o     source     move_valid, move_dx, move_dy, left_click
// APB       slave      motion_gain, dead_zone, tap_max_ms, double_gap_ms
//
// Each request passes through the input register and then the result
// register. One request is accepted per cycle while the output is not
// stalled; the touch state is updated as a request moves from the input
// register into the result register. A stalled output holds both stages,
// and the input register still takes one more request while the result waits.
// Reset clears the touch state and returns the registers to their defaults.
module touchpad_motion_and_double_tap import tpmd_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  tpmd_in_if.sink             in_i,
  tpmd_out_if.source          out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned QW = COORD_BITS + 5;

  tpmd_cfg_t cfg;

  tpmd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input register.
  logic                  in_vld_q;
  logic                  tv_q;
  logic [COORD_BITS-1:0] x_q, y_q;
  logic [TimeW-1:0]      t_q;
  logic                  in_take, advance;

  // Result register.
  logic               out_vld_q;
  logic               move_valid_q, move_valid_d;
  logic [MotionW-1:0] dx_q, dx_d, dy_q, dy_d;
  logic               click_q, click_d;

  // Touch state.
  logic                  touching_q, touching_d;
  logic [COORD_BITS-1:0] last_x_q, last_x_d, last_y_q, last_y_d;
  logic [TimeW-1:0]      start_q, start_d, tap_time_q, tap_time_d;
  logic                  pending_q, pending_d;

  assign advance    = in_vld_q & (~out_vld_q | out_o.ready);
  assign in_i.ready = ~in_vld_q | advance;
  assign in_take    = in_i.valid & in_i.ready;

  // Input stage handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      tv_q <= in_i.touch_valid;
      x_q  <= in_i.touch_x;
      y_q  <= in_i.touch_y;
      t_q  <= in_i.now_time;
    end
  end

  // Scaled deltas; y is negated so that up is positive.
  logic signed [COORD_BITS:0] raw_dx, raw_dy;
  logic [QW-1:0]              mag_dx, mag_dy;
  logic [MotionW-1:0]         val_dx, val_dy;
  logic [QW:0]                mag_sum;

  assign raw_dx = $signed({1'b0, x_q}) - $signed({1'b0, last_x_q});
  assign raw_dy = $signed({1'b0, last_y_q}) - $signed({1'b0, y_q});

  tpmd_scale #(.COORD_BITS(COORD_BITS)) u_scale_x (
    .raw_i   (raw_dx),
    .gain_i  (cfg.motion_gain),
    .mag_o   (mag_dx),
    .value_o (val_dx)
  );

  tpmd_scale #(.COORD_BITS(COORD_BITS)) u_scale_y (
    .raw_i   (raw_dy),
    .gain_i  (cfg.motion_gain),
    .mag_o   (mag_dy),
    .value_o (val_dy)
  );

  assign mag_sum = (QW+1)'(mag_dx) + (QW+1)'(mag_dy);

  // Touch tracking and tap decisions.
  logic [TimeW-1:0] held_ms, gap_ms, age_ms;

  assign held_ms = t_q - start_q;
  assign gap_ms  = t_q - tap_time_q;

  always_comb begin
    touching_d   = touching_q;
    last_x_d     = last_x_q;
    last_y_d     = last_y_q;
    start_d      = start_q;
    tap_time_d   = tap_time_q;
    pending_d    = pending_q;
    move_valid_d = 1'b0;
    dx_d         = '0;
    dy_d         = '0;
    click_d      = 1'b0;
    age_ms       = gap_ms;
    if (tv_q && !touching_q) begin
      // Touch-down: latch position and time.
      touching_d = 1'b1;
      last_x_d   = x_q;
      last_y_d   = y_q;
      start_d    = t_q;
    end else if (tv_q) begin
      // Held: report a move once the dead zone is reached.
      if (mag_sum >= (QW+1)'(cfg.dead_zone)) begin
        move_valid_d = 1'b1;
        dx_d         = val_dx;
        dy_d         = val_dy;
        last_x_d     = x_q;
        last_y_d     = y_q;
      end
    end else begin
      // Release: a short touch is a tap, a second close tap is a click.
      if (touching_q) begin
        touching_d = 1'b0;
        if (held_ms <= TimeW'(cfg.tap_max_ms)) begin
          if (pending_q && (gap_ms <= TimeW'(cfg.double_gap_ms))) begin
            click_d   = 1'b1;
            pending_d = 1'b0;
          end else begin
            pending_d  = 1'b1;
            tap_time_d = t_q;
            age_ms     = '0;
          end
        end
      end
      // Release or idle: an old pending tap expires.
      if (pending_d && (age_ms > TimeW'(cfg.double_gap_ms))) begin
        pending_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touching_q <= 1'b0;
      last_x_q   <= '0;
      last_y_q   <= '0;
      start_q    <= '0;
      tap_time_q <= '0;
      pending_q  <= 1'b0;
    end else if (advance) begin
      touching_q <= touching_d;
      last_x_q   <= last_x_d;
      last_y_q   <= last_y_d;
      start_q    <= start_d;
      tap_time_q <= tap_time_d;
      pending_q  <= pending_d;
    end
  end

  // Result stage handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      move_valid_q <= move_valid_d;
      dx_q         <= dx_d;
      dy_q         <= dy_d;
      click_q      <= click_d;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.move_valid = move_valid_q;
  assign out_o.move_dx    = dx_q;
  assign out_o.move_dy    = dy_q;
  assign out_o.left_click = click_q;

endmodule

>>> src/tpmd_checker.sv
`timescale 1ns / 1ps

module tpmd_checker import tpmd_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic               move_valid_i,
  input logic [MotionW-1:0] move_dx_i,
  input logic [MotionW-1:0] move_dy_i,
  input logic               left_click_i
);

  // With the result stage empty the block always takes a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input not ready while the result stage is empty");

  // Motion fields are zero unless a move is reported.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !move_valid_i |-> (move_dx_i == '0) && (move_dy_i == '0))
    else $error("motion fields nonzero without a move");

  // A click only comes on release, never with a move.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(move_valid_i && left_click_i))
    else $error("move and click reported together");

  // A stalled result stays in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(move_valid_i)
      && $stable(move_dx_i) && $stable(move_dy_i) && $stable(left_click_i))
    else $error("stalled result changed");

endmodule

bind touchpad_motion_and_double_tap tpmd_checker u_tpmd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .move_valid_i (out_o.move_valid),
  .move_dx_i    (out_o.move_dx),
  .move_dy_i    (out_o.move_dy),
  .left_click_i (out_o.left_click)
);
